/* hw/rtl/cro_pkg.sv */
// ----------------------------------------------------------------------------
// cro_pkg
// Shared widths, register indexes and colour helpers for the circle overlay.
// ----------------------------------------------------------------------------
package cro_pkg;

    localparam int COORD_BITS   = 12;
    localparam int COLOR_BITS   = 24;
    localparam int CH_BITS      = 8;
    localparam int CFG_IDX_BITS = 3;

    // dx*dx and friends
    localparam int SQ_BITS  = 2 * COORD_BITS;
    // r + t needs one more bit
    localparam int HI_BITS  = COORD_BITS + 1;
    localparam int HSQ_BITS = 2 * HI_BITS;
    // common width for distance compares
    localparam int CMP_BITS = 2 * COORD_BITS + 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_COL  = 3'd0,
        CFG_CENTER_ROW  = 3'd1,
        CFG_RADIUS      = 3'd2,
        CFG_THICKNESS   = 3'd3,
        CFG_FILL_ENABLE = 3'd4,
        CFG_FILL_COLOR  = 3'd5,
        CFG_LINE_COLOR  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] red;
    } pixel_t;

    function automatic pixel_t unpack_color(input logic [COLOR_BITS-1:0] c);
        pixel_t p;
        p.blue  = c[3*CH_BITS-1:2*CH_BITS];
        p.green = c[2*CH_BITS-1:CH_BITS];
        p.red   = c[CH_BITS-1:0];
        return p;
    endfunction

endpackage

/* hw/rtl/circle_ring_overlay.sv */
// ----------------------------------------------------------------------------
// circle_ring_overlay
// Draws a circle outline, optionally a filled disc, onto a pixel stream.
// ----------------------------------------------------------------------------
// Usage
//   Pixel channel: a pixel transaction is taken at a rising edge with start
//   high and busy low. busy stays low, so one pixel may enter every cycle.
//   Result channel: done is high for exactly one cycle while out_blue,
//   out_green and out_red carry the result; results leave in input order.
//   Throughput is one pixel per cycle through the four-stage pipeline
//   (offsets, squares, bound sums, compare and colour select).
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Index 0..6 selects centre column, centre row,
//   radius, thickness, fill enable, fill colour and line colour; other
//   indexes are ignored. Write only while no pixel is in flight.
//   Reset: rst_n zeroes config and valid registers, emptying the pipeline.
//   The receiver cannot stall; nothing holds results back.
// ----------------------------------------------------------------------------
module circle_ring_overlay (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cro_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cro_pkg::COLOR_BITS-1:0]    cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [cro_pkg::COORD_BITS-1:0]    pixel_col,
    input  logic [cro_pkg::COORD_BITS-1:0]    pixel_row,
    input  logic [cro_pkg::CH_BITS-1:0]       in_blue,
    input  logic [cro_pkg::CH_BITS-1:0]       in_green,
    input  logic [cro_pkg::CH_BITS-1:0]       in_red,
    output logic                              done,
    output logic [cro_pkg::CH_BITS-1:0]       out_blue,
    output logic [cro_pkg::CH_BITS-1:0]       out_green,
    output logic [cro_pkg::CH_BITS-1:0]       out_red
);
    import cro_pkg::*;

    // configuration
    logic [COORD_BITS-1:0] center_col_reg;
    logic [COORD_BITS-1:0] center_row_reg;
    logic [COORD_BITS-1:0] radius_reg;
    logic [COORD_BITS-1:0] thickness_reg;
    logic                  fill_enable_reg;
    logic [COLOR_BITS-1:0] fill_color_reg;
    logic [COLOR_BITS-1:0] line_color_reg;

    logic cfg_we;
    logic in_accept;

    // stage 1
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_adx_reg,  s1_adx_next;
    logic [COORD_BITS-1:0] s1_ady_reg,  s1_ady_next;
    logic [COORD_BITS-1:0] s1_r_reg;
    logic [HI_BITS-1:0]    s1_hi_reg,   s1_hi_next;
    logic [COORD_BITS-1:0] s1_lo_reg,   s1_lo_next;
    logic                  s1_lo_pos_reg, s1_lo_pos_next;
    pixel_t                s1_pix_reg;

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   lo_diff;

    // stage 2
    logic                  s2_valid_reg;
    logic [SQ_BITS-1:0]    s2_sqx_reg, s2_sqy_reg, s2_rr_reg, s2_ll_reg;
    logic [HSQ_BITS-1:0]   s2_hh_reg;
    logic [COORD_BITS-1:0] s2_r_reg;
    logic [HI_BITS-1:0]    s2_hi_reg;
    logic [COORD_BITS-1:0] s2_lo_reg;
    logic                  s2_lo_pos_reg;
    pixel_t                s2_pix_reg;

    // stage 3
    logic                  s3_valid_reg;
    logic [CMP_BITS-1:0]   s3_d2_reg,      s3_d2_next;
    logic [CMP_BITS-1:0]   s3_fill_bnd_reg, s3_fill_bnd_next;
    logic [CMP_BITS-1:0]   s3_hi_bnd_reg,  s3_hi_bnd_next;
    logic [CMP_BITS-1:0]   s3_lo_bnd_reg,  s3_lo_bnd_next;
    logic                  s3_lo_pos_reg;
    pixel_t                s3_pix_reg;

    // stage 4
    logic                  in_disc;
    logic                  in_band;
    logic                  done_reg;
    pixel_t                out_pix_reg, out_pix_next;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg  <= '0;
            center_row_reg  <= '0;
            radius_reg      <= '0;
            thickness_reg   <= '0;
            fill_enable_reg <= 1'b0;
            fill_color_reg  <= '0;
            line_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_COL:  center_col_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_CENTER_ROW:  center_row_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:      radius_reg      <= cfg_data[COORD_BITS-1:0];
                CFG_THICKNESS:   thickness_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_FILL_ENABLE: fill_enable_reg <= cfg_data[0];
                CFG_FILL_COLOR:  fill_color_reg  <= cfg_data;
                CFG_LINE_COLOR:  line_color_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: offsets and band limits
    always_comb
    begin
        dx          = {1'b0, pixel_col} - {1'b0, center_col_reg};
        dy          = {1'b0, pixel_row} - {1'b0, center_row_reg};
        s1_adx_next = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        s1_ady_next = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        s1_hi_next  = {1'b0, radius_reg} + {1'b0, thickness_reg};
        lo_diff     = {1'b0, radius_reg} - {1'b0, thickness_reg};
        s1_lo_next  = lo_diff[COORD_BITS-1:0];
        // inner bound of zero or below always passes
        s1_lo_pos_next = !lo_diff[COORD_BITS] && (lo_diff != '0);
    end

    // stage 3: d2 and exact rounding bounds
    always_comb
    begin
        s3_d2_next       = CMP_BITS'(s2_sqx_reg) + CMP_BITS'(s2_sqy_reg);
        s3_fill_bnd_next = CMP_BITS'(s2_rr_reg) + CMP_BITS'(s2_r_reg);
        s3_hi_bnd_next   = CMP_BITS'(s2_hh_reg) + CMP_BITS'(s2_hi_reg);
        s3_lo_bnd_next   = CMP_BITS'(s2_ll_reg) - CMP_BITS'(s2_lo_reg) + CMP_BITS'(1);
    end

    // stage 4: compare and select
    always_comb
    begin
        in_disc = fill_enable_reg && (s3_d2_reg <= s3_fill_bnd_reg);
        in_band = (!s3_lo_pos_reg || (s3_d2_reg >= s3_lo_bnd_reg))
                  && (s3_d2_reg <= s3_hi_bnd_reg);
        if (in_disc)
            out_pix_next = unpack_color(fill_color_reg);
        else if (in_band)
            out_pix_next = unpack_color(line_color_reg);
        else
            out_pix_next = s3_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_adx_reg    <= s1_adx_next;
        s1_ady_reg    <= s1_ady_next;
        s1_r_reg      <= radius_reg;
        s1_hi_reg     <= s1_hi_next;
        s1_lo_reg     <= s1_lo_next;
        s1_lo_pos_reg <= s1_lo_pos_next;
        s1_pix_reg    <= '{blue: in_blue, green: in_green, red: in_red};

        s2_sqx_reg    <= SQ_BITS'(s1_adx_reg) * SQ_BITS'(s1_adx_reg);
        s2_sqy_reg    <= SQ_BITS'(s1_ady_reg) * SQ_BITS'(s1_ady_reg);
        s2_rr_reg     <= SQ_BITS'(s1_r_reg) * SQ_BITS'(s1_r_reg);
        s2_ll_reg     <= SQ_BITS'(s1_lo_reg) * SQ_BITS'(s1_lo_reg);
        s2_hh_reg     <= HSQ_BITS'(s1_hi_reg) * HSQ_BITS'(s1_hi_reg);
        s2_r_reg      <= s1_r_reg;
        s2_hi_reg     <= s1_hi_reg;
        s2_lo_reg     <= s1_lo_reg;
        s2_lo_pos_reg <= s1_lo_pos_reg;
        s2_pix_reg    <= s1_pix_reg;

        s3_d2_reg       <= s3_d2_next;
        s3_fill_bnd_reg <= s3_fill_bnd_next;
        s3_hi_bnd_reg   <= s3_hi_bnd_next;
        s3_lo_bnd_reg   <= s3_lo_bnd_next;
        s3_lo_pos_reg   <= s2_lo_pos_reg;
        s3_pix_reg      <= s2_pix_reg;

        out_pix_reg   <= out_pix_next;
    end

    assign done      = done_reg;
    assign out_blue  = out_pix_reg.blue;
    assign out_green = out_pix_reg.green;
    assign out_red   = out_pix_reg.red;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> ##4 done)
        else $error("pixel transaction not delivered after four cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s3_valid_reg))
        else $error("result strobe without a pixel in flight");

    a_fill_wins: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && in_disc |=> out_pix_reg == unpack_color(fill_color_reg))
        else $error("disc interior not given fill colour");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !in_disc && !in_band |=> out_pix_reg == $past(s3_pix_reg))
        else $error("pixel outside the circle was altered");

endmodule
